### sv/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg
// types, codes and helpers shared by the sphere collision response unit
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int NUM_W   = 96;
    localparam int DEN_W   = 62;
    localparam int Q_W     = 41;
    localparam int P_SPLIT = 30;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SELF,
        S_SCAN,
        S_C1,
        S_C2,
        S_C3,
        S_QA,
        S_QB,
        S_QC,
        S_QD,
        S_QW
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHK,
        D_RUN,
        D_FIN
    } t_div_state;

    typedef struct packed {
        logic               command;
        logic [5:0]         entry_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [7:0]         mass;
        logic [23:0]        radius;
    } t_cmd;

    typedef struct packed {
        logic               collided;
        logic [5:0]         partner_index;
        logic signed [31:0] self_vel_x;
        logic signed [31:0] self_vel_y;
        logic signed [31:0] self_vel_z;
        logic signed [31:0] other_vel_x;
        logic signed [31:0] other_vel_y;
        logic signed [31:0] other_vel_z;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [7:0]       mass;
        logic [23:0]      radius;
    } t_entry;

    function automatic logic [31:0] sat32(input logic signed [42:0] v);
        logic [31:0] r;
        if (v > 43'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -43'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### sv/sce_entry_mem.sv
// ----------------------------------------------------------------------------
// sce_entry_mem
// sphere entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module sce_entry_mem import sce_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/sce_div.sv
// ----------------------------------------------------------------------------
// sce_div
// restoring divider, one quotient bit per cycle, rounded and clamped to 2^40
// ----------------------------------------------------------------------------
module sce_div import sce_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(Q_W + 1);
    localparam logic [Q_W:0] Q_CLAMP = (Q_W + 1)'(1) << (Q_W - 1);

    t_div_state r_st, n_st;
    logic [DEN_W-1:0] r_den, r_rem;
    logic [Q_W-1:0]   r_low, r_q;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   t_try;
    logic             t_ge;
    logic             inc;
    logic [Q_W:0]     qq;

    assign t_try = {r_rem, r_low[Q_W-1]};
    assign t_ge  = t_try >= {1'b0, r_den};
    assign inc   = {r_rem, 1'b0} >= {1'b0, r_den};
    assign qq    = {1'b0, r_q} + (Q_W + 1)'(inc);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            D_IDLE: if (i_start) n_st = D_CHK;
            D_CHK:  n_st = (r_rem >= r_den) ? D_IDLE : D_RUN;
            D_RUN:  if (r_cnt == CNT_W'(Q_W - 1)) n_st = D_FIN;
            D_FIN:  n_st = D_IDLE;
            default: n_st = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            o_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            o_done <= 1'b0;
            case (r_st)
                D_IDLE: begin
                    if (i_start) begin
                        r_den <= i_den;
                        r_rem <= DEN_W'(i_num[NUM_W-1:Q_W]);
                        r_low <= i_num[Q_W-1:0];
                    end
                end
                D_CHK: begin
                    r_cnt <= '0;
                    r_q   <= '0;
                    if (r_rem >= r_den) begin
                        o_quot <= Q_CLAMP[Q_W-1:0];
                        o_done <= 1'b1;
                    end
                end
                D_RUN: begin
                    if (t_ge) begin
                        r_rem <= DEN_W'(t_try - {1'b0, r_den});
                    end else begin
                        r_rem <= t_try[DEN_W-1:0];
                    end
                    r_q   <= {r_q[Q_W-2:0], t_ge};
                    r_low <= {r_low[Q_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                end
                D_FIN: begin
                    o_quot <= (qq > Q_CLAMP) ? Q_CLAMP[Q_W-1:0] : qq[Q_W-1:0];
                    o_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

### sv/sphere_collision_elastic_response_unit.sv
// ----------------------------------------------------------------------------
// sphere_collision_elastic_response_unit
// sphere table with overlap scan and elastic velocity exchange
// ----------------------------------------------------------------------------
// write: strobe in the cycle after the transfer, busy stays low
// query: strobe from S_SELF for an invalid entry, from S_SCAN once the scan ends on a miss
// hit at entry j: the scan stops at the hit, the strobe follows S_C3 for
//   coincident centers or a zero mass sum, else six quotients (clamped ones end early) come first
// busy is low in the strobe cycle; reset starts a clearing pass over all SPHERES entries
//   of the entry memory with busy high; results cannot be stalled
module sphere_collision_elastic_response_unit import sce_pkg::*; #(
    parameter int SPHERES = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    localparam int AW = $clog2(SPHERES);
    localparam logic [AW-1:0] LAST = AW'(SPHERES - 1);

    t_state r_state, n_state;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_entry        mem_wdata, mem_rdata;

    logic          accept, idx_ok;
    logic [AW-1:0] idx_addr;

    logic [AW-1:0] r_j;
    logic          r_scan_end;
    logic          r_idx_ok;
    logic [AW-1:0] r_self_idx;
    logic signed [31:0] r_self_pos [3];
    logic signed [31:0] r_v1 [3];
    logic [7:0]    r_m1;
    logic [23:0]   r_self_rad;

    // scan pipeline
    logic          r_p1_v;
    logic [AW-1:0] r_p1_idx;
    logic signed [32:0] dc1 [3];
    logic [32:0]   mag1 [3];
    logic [25:0]   rsum1;
    logic          far1, ok1;

    logic          r_s2_v;
    logic [AW-1:0] r_s2_idx;
    logic [24:0]   r_s2_mag [3];
    logic signed [25:0] r_s2_d [3];
    logic [24:0]   r_s2_rsum;
    logic signed [31:0] r_s2_vel [3];
    logic [7:0]    r_s2_mass;

    logic          r_s3_v;
    logic [AW-1:0] r_s3_idx;
    logic [49:0]   r_s3_sq [3];
    logic [49:0]   r_s3_r2;
    logic signed [25:0] r_s3_d [3];
    logic signed [31:0] r_s3_vel [3];
    logic [7:0]    r_s3_mass;
    logic [51:0]   sum3;
    logic          hit3, scan_miss;

    // exchange
    logic [AW-1:0] r_hit_idx;
    logic signed [25:0] r_d [3];
    logic signed [31:0] r_v2 [3];
    logic [7:0]    r_m2;
    logic [49:0]   r_dsq [3];
    logic signed [58:0] r_dvp [3];
    logic signed [32:0] dv_c [3];
    logic [51:0]   r_dd;
    logic signed [60:0] r_p;
    logic [8:0]    r_msum;
    logic [DEN_W-1:0] r_den;
    logic [59:0]   r_pmag;
    logic          r_pneg;
    logic [1:0]    r_k;
    logic          r_side;
    logic [8:0]    mw;
    logic [24:0]   dmag;
    logic [34:0]   r_a;
    logic [64:0]   r_pp0, r_pp1;
    logic [NUM_W-1:0] num;
    logic          div_start, div_done;
    logic [Q_W-1:0] div_quot;
    logic          neg;
    logic signed [41:0] sd;
    logic [31:0]   r_rs [3];
    logic [31:0]   r_ro [3];
    logic [31:0]   new_self, new_other;

    assign accept   = start && !busy;
    assign idx_ok   = int'(i_cmd.entry_index) < SPHERES;
    assign idx_addr = AW'(i_cmd.entry_index);

    sce_entry_mem #(.DEPTH(SPHERES), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // stage 1 combinational check
    always_comb begin
        far1 = 1'b0;
        for (int k = 0; k < 3; k++) begin
            dc1[k]  = {r_self_pos[k][31], r_self_pos[k]}
                    - $signed({mem_rdata.pos[k][31], mem_rdata.pos[k]});
            mag1[k] = dc1[k][32] ? 33'(-dc1[k]) : 33'(dc1[k]);
        end
        rsum1 = {2'b0, r_self_rad} + {2'b0, mem_rdata.radius};
        for (int k = 0; k < 3; k++) begin
            if (mag1[k] > {7'd0, rsum1}) far1 = 1'b1;
        end
        ok1 = r_p1_v && mem_rdata.valid && (r_p1_idx != r_self_idx) && !far1;
    end

    assign sum3      = {2'b0, r_s3_sq[0]} + {2'b0, r_s3_sq[1]} + {2'b0, r_s3_sq[2]};
    assign hit3      = r_s3_v && (sum3 <= {2'b0, r_s3_r2});
    assign scan_miss = r_scan_end && !r_p1_v && !r_s2_v && !r_s3_v;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dv_c[k] = {r_v2[k][31], r_v2[k]} - {r_v1[k][31], r_v1[k]};
        end
        mw   = r_side ? {r_m1, 1'b0} : {r_m2, 1'b0};
        dmag = r_d[r_k][25] ? 25'(-r_d[r_k]) : 25'(r_d[r_k]);
        num  = NUM_W'(r_pp0) + (NUM_W'(r_pp1) << P_SPLIT);
        neg  = r_d[r_k][25] ^ r_pneg;
        sd   = neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        new_self  = sat32(43'(r_v1[r_k]) + 43'(sd));
        new_other = sat32(43'(r_v2[r_k]) - 43'(sd));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_j == LAST) n_state = S_IDLE;
            S_IDLE:  if (accept && i_cmd.command == CMD_QUERY) n_state = S_SELF;
            S_SELF:  n_state = (r_idx_ok && mem_rdata.valid) ? S_SCAN : S_IDLE;
            S_SCAN: begin
                if (hit3) n_state = S_C1;
                else if (scan_miss) n_state = S_IDLE;
            end
            S_C1: n_state = S_C2;
            S_C2: n_state = S_C3;
            S_C3: n_state = (r_dd == '0 || r_msum == '0) ? S_IDLE : S_QA;
            S_QA: n_state = S_QB;
            S_QB: n_state = S_QC;
            S_QC: n_state = S_QD;
            S_QD: n_state = S_QW;
            S_QW: begin
                if (div_done) n_state = (r_side && r_k == 2'd2) ? S_IDLE : S_QA;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        busy      = r_state != S_IDLE;
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = '0;
        mem_raddr = r_j;
        div_start = r_state == S_QD;
        unique case (r_state)
            S_CLEAR: mem_we = 1'b1;
            S_IDLE: begin
                mem_raddr = idx_addr;
                mem_waddr = idx_addr;
                mem_we    = accept && i_cmd.command == CMD_WRITE && idx_ok;
                mem_wdata.valid  = 1'b1;
                mem_wdata.pos    = {i_cmd.pos_z, i_cmd.pos_y, i_cmd.pos_x};
                mem_wdata.vel    = {i_cmd.vel_z, i_cmd.vel_y, i_cmd.vel_x};
                mem_wdata.mass   = i_cmd.mass;
                mem_wdata.radius = i_cmd.radius;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_j        <= '0;
            r_scan_end <= 1'b0;
            r_p1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            r_p1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            case (r_state)
                S_CLEAR: r_j <= r_j + 1'b1;
                S_IDLE: begin
                    if (accept) begin
                        r_idx_ok   <= idx_ok;
                        r_self_idx <= idx_addr;
                        if (i_cmd.command == CMD_WRITE) begin
                            o_done   <= 1'b1;
                            o_result <= '0;
                        end
                    end
                end
                S_SELF: begin
                    for (int k = 0; k < 3; k++) begin
                        r_self_pos[k] <= mem_rdata.pos[k];
                        r_v1[k]       <= mem_rdata.vel[k];
                    end
                    r_m1       <= mem_rdata.mass;
                    r_self_rad <= mem_rdata.radius;
                    r_j        <= '0;
                    r_scan_end <= 1'b0;
                    if (!(r_idx_ok && mem_rdata.valid)) begin
                        o_done   <= 1'b1;
                        o_result <= '0;
                    end
                end
                S_SCAN: begin
                    if (!r_scan_end) begin
                        r_p1_v   <= 1'b1;
                        r_p1_idx <= r_j;
                        r_j      <= r_j + 1'b1;
                        if (r_j == LAST) r_scan_end <= 1'b1;
                    end
                    r_s2_v    <= ok1;
                    r_s2_idx  <= r_p1_idx;
                    r_s2_rsum <= rsum1[24:0];
                    r_s2_mass <= mem_rdata.mass;
                    for (int k = 0; k < 3; k++) begin
                        r_s2_mag[k] <= mag1[k][24:0];
                        r_s2_d[k]   <= dc1[k][25:0];
                        r_s2_vel[k] <= mem_rdata.vel[k];
                    end
                    r_s3_v    <= r_s2_v;
                    r_s3_idx  <= r_s2_idx;
                    r_s3_r2   <= r_s2_rsum * r_s2_rsum;
                    r_s3_mass <= r_s2_mass;
                    for (int k = 0; k < 3; k++) begin
                        r_s3_sq[k]  <= r_s2_mag[k] * r_s2_mag[k];
                        r_s3_d[k]   <= r_s2_d[k];
                        r_s3_vel[k] <= r_s2_vel[k];
                    end
                    if (hit3) begin
                        r_hit_idx <= r_s3_idx;
                        r_m2      <= r_s3_mass;
                        for (int k = 0; k < 3; k++) begin
                            r_d[k]  <= r_s3_d[k];
                            r_v2[k] <= r_s3_vel[k];
                        end
                    end else if (scan_miss) begin
                        o_done   <= 1'b1;
                        o_result <= '0;
                    end
                end
                S_C1: begin
                    for (int k = 0; k < 3; k++) begin
                        r_dsq[k] <= 50'(r_d[k] * r_d[k]);
                        r_dvp[k] <= dv_c[k] * r_d[k];
                    end
                end
                S_C2: begin
                    r_dd   <= {2'b0, r_dsq[0]} + {2'b0, r_dsq[1]} + {2'b0, r_dsq[2]};
                    r_p    <= 61'(r_dvp[0]) + 61'(r_dvp[1]) + 61'(r_dvp[2]);
                    r_msum <= {1'b0, r_m1} + {1'b0, r_m2};
                end
                S_C3: begin
                    r_den  <= DEN_W'(r_msum * r_dd);
                    r_pmag <= r_p[60] ? 60'(-r_p) : 60'(r_p);
                    r_pneg <= r_p[60];
                    r_k    <= '0;
                    r_side <= 1'b0;
                    if (r_dd == '0 || r_msum == '0) begin
                        o_done                 <= 1'b1;
                        o_result.collided      <= 1'b1;
                        o_result.partner_index <= 6'(r_hit_idx);
                        o_result.self_vel_x    <= r_v1[0];
                        o_result.self_vel_y    <= r_v1[1];
                        o_result.self_vel_z    <= r_v1[2];
                        o_result.other_vel_x   <= r_v2[0];
                        o_result.other_vel_y   <= r_v2[1];
                        o_result.other_vel_z   <= r_v2[2];
                    end
                end
                S_QA: r_a   <= dmag * mw;
                S_QB: r_pp0 <= r_a * r_pmag[P_SPLIT-1:0];
                S_QC: r_pp1 <= r_a * r_pmag[2*P_SPLIT-1:P_SPLIT];
                S_QW: begin
                    if (div_done) begin
                        if (!r_side) begin
                            r_rs[r_k] <= new_self;
                            r_side    <= 1'b1;
                        end else begin
                            r_ro[r_k] <= new_other;
                            r_side    <= 1'b0;
                            r_k       <= r_k + 1'b1;
                            if (r_k == 2'd2) begin
                                o_done                 <= 1'b1;
                                o_result.collided      <= 1'b1;
                                o_result.partner_index <= 6'(r_hit_idx);
                                o_result.self_vel_x    <= r_rs[0];
                                o_result.self_vel_y    <= r_rs[1];
                                o_result.self_vel_z    <= r_rs[2];
                                o_result.other_vel_x   <= r_ro[0];
                                o_result.other_vel_y   <= r_ro[1];
                                o_result.other_vel_z   <= new_other;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
